/* sv/dgdf_pkg.sv */
// shared constants for the datagram deframer: result kinds and crc-32 constants
// no dependencies
`default_nettype none

package dgdf_pkg;

  localparam int unsigned CRC_W = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_DEST  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_ZERO  = 3'd3;
  localparam logic [2:0] KIND_TRAIL = 3'd4;

endpackage

`default_nettype wire

/* sv/dgdf_crc_byte.sv */
// one-byte update of a reflected crc-32, purely combinational
// depends on dgdf_pkg
`default_nettype none

module dgdf_crc_byte
  import dgdf_pkg::*;
(
  input  wire logic [CRC_W-1:0] crc_in,
  input  wire logic [7:0]       data,
  output logic      [CRC_W-1:0] crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-8){1'b0}}, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

/* sv/datagram_deframer_crc32.sv */
// datagram deframer with crc-32 check, top level
// depends on dgdf_pkg and dgdf_crc_byte
//
// Parses a byte stream laid out as: version byte, big-endian crc-32, a
// destination count (1 to 255), the destination bytes, a big-endian 32-bit
// payload length, then the payload. Every destination and payload byte is
// reported with its index in its section; the result that completes the
// datagram carries last and crc_ok (zlib crc-32 over everything from the count
// byte to the last payload byte, compared with the received field). A zero
// count byte is rejected and skipped; a zero length completes on the last
// length byte with an empty-payload result. Bytes after completion come out as
// trailing bytes with a saturating index. cmd = 1 restarts the parser.
// Throughput is one byte per clock: each transaction is parsed in the cycle it
// is accepted and its result lands in the output register, and the input
// stays ready while that register is empty or being drained, so a result is
// valid in the cycle after its byte. The byte-wide crc update is the longest path.
`default_nettype none

module datagram_deframer_crc32
  import dgdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [7:0]  byte_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [31:0]      index,
  output logic [7:0]       value,
  output logic             last,
  output logic             crc_ok,
  output logic [7:0]       version
);

  // parser phases
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_CRC     = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_DEST    = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_TRAIL   = 3'd6;

  localparam logic [31:0] FIELD_BYTES = 32'd4;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

  // parser state
  logic [2:0]       phase, phase_next;
  logic [31:0]      section_count, section_count_next;
  logic [7:0]       version_byte, version_byte_next;
  logic [31:0]      received_crc, received_crc_next;
  logic [7:0]       destination_count, destination_count_next;
  logic [31:0]      payload_length, payload_length_next;
  logic [CRC_W-1:0] running_crc, running_crc_next;
  logic             complete_flag, complete_flag_next;

  // result of the transaction being accepted
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [31:0] res_index;
  logic [7:0]  res_value;
  logic        res_last;

  logic [CRC_W-1:0] crc_upd;
  logic [31:0]      cnt_inc;
  logic [31:0]      len_shift;
  logic             in_fire;

  dgdf_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (byte_in),
    .crc_out (crc_upd)
  );

  // output register is free when empty or being drained this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cnt_inc   = section_count + 32'd1;
  assign len_shift = {payload_length[23:0], byte_in};

  always_comb begin
    phase_next             = phase;
    section_count_next     = section_count;
    version_byte_next      = version_byte;
    received_crc_next      = received_crc;
    destination_count_next = destination_count;
    payload_length_next    = payload_length;
    running_crc_next       = running_crc;
    complete_flag_next     = complete_flag;
    res_valid              = 1'b0;
    res_kind               = KIND_DEST;
    res_index              = '0;
    res_value              = byte_in;
    res_last               = 1'b0;

    if (cmd) begin
      // restart: back to reset values, no result
      phase_next             = PH_VERSION;
      section_count_next     = '0;
      version_byte_next      = '0;
      received_crc_next      = '0;
      destination_count_next = '0;
      payload_length_next    = '0;
      running_crc_next       = CRC_INIT;
      complete_flag_next     = 1'b0;
    end else begin
      unique case (phase)
        PH_VERSION: begin
          version_byte_next  = byte_in;
          phase_next         = PH_CRC;
          section_count_next = '0;
        end
        PH_CRC: begin
          received_crc_next  = {received_crc[23:0], byte_in};
          section_count_next = cnt_inc;
          if (cnt_inc >= FIELD_BYTES) begin
            phase_next         = PH_COUNT;
            section_count_next = '0;
          end
        end
        PH_COUNT: begin
          if (byte_in == 8'd0) begin
            // zero count is rejected and kept out of the crc
            res_valid = 1'b1;
            res_kind  = KIND_ZERO;
          end else begin
            destination_count_next = byte_in;
            running_crc_next       = crc_upd;
            phase_next             = PH_DEST;
            section_count_next     = '0;
          end
        end
        PH_DEST: begin
          running_crc_next   = crc_upd;
          section_count_next = cnt_inc;
          res_valid          = 1'b1;
          res_kind           = KIND_DEST;
          res_index          = section_count;
          if (cnt_inc >= {24'd0, destination_count}) begin
            phase_next         = PH_LENGTH;
            section_count_next = '0;
          end
        end
        PH_LENGTH: begin
          payload_length_next = len_shift;
          running_crc_next    = crc_upd;
          section_count_next  = cnt_inc;
          if (cnt_inc >= FIELD_BYTES) begin
            section_count_next = '0;
            if (len_shift == 32'd0) begin
              // empty payload completes on the last length byte
              phase_next         = PH_TRAIL;
              complete_flag_next = 1'b1;
              res_valid          = 1'b1;
              res_kind           = KIND_EMPTY;
              res_value          = '0;
              res_last           = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          res_valid        = 1'b1;
          res_kind         = KIND_DATA;
          res_index        = section_count;
          if (section_count >= payload_length - 32'd1) begin
            phase_next         = PH_TRAIL;
            section_count_next = '0;
            complete_flag_next = 1'b1;
            res_last           = 1'b1;
          end else begin
            section_count_next = cnt_inc;
          end
        end
        default: begin
          // trailing bytes, index saturates
          phase_next = PH_TRAIL;
          res_valid  = 1'b1;
          res_kind   = KIND_TRAIL;
          res_index  = section_count;
          if (section_count != CNT_MAX) begin
            section_count_next = cnt_inc;
          end
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_VERSION;
      section_count     <= '0;
      version_byte      <= '0;
      received_crc      <= '0;
      destination_count <= '0;
      payload_length    <= '0;
      running_crc       <= CRC_INIT;
      complete_flag     <= 1'b0;
    end else if (in_fire) begin
      phase             <= phase_next;
      section_count     <= section_count_next;
      version_byte      <= version_byte_next;
      received_crc      <= received_crc_next;
      destination_count <= destination_count_next;
      payload_length    <= payload_length_next;
      running_crc       <= running_crc_next;
      complete_flag     <= complete_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // crc_ok uses the crc after this byte and the version as held after it
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind    <= res_kind;
      index   <= res_index;
      value   <= res_value;
      last    <= res_last;
      crc_ok  <= res_last && ((running_crc_next ^ CRC_INIT) == received_crc_next);
      version <= version_byte_next;
    end
  end

  // crc_ok is only ever set on a completing result
  a_crc_ok_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!crc_ok || last))
    else $error("crc_ok without last");

  // a completing result only comes from a payload byte or an empty payload
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (kind == KIND_DATA || kind == KIND_EMPTY))
    else $error("last on wrong kind");

  // restart returns the parser to its initial state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd) |=> (phase == PH_VERSION && running_crc == CRC_INIT
                          && !complete_flag))
    else $error("restart did not clear parser");

  // once complete, the parser stays in the trailing phase until restart
  a_complete_trail: assert property (@(posedge clk) disable iff (rst)
    complete_flag |-> (phase == PH_TRAIL))
    else $error("complete outside trailing phase");

endmodule

`default_nettype wire

/* bench/dgdf_result_checker.sv */
// result checker for the datagram deframer: tracks the parse of every accepted
// input transaction, queues the results it predicts and compares them in order
// depends on dgdf_pkg
module dgdf_result_checker
  import dgdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  byte_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [31:0] index,
  input  logic [7:0]  value,
  input  logic        last,
  input  logic        crc_ok,
  input  logic [7:0]  version,
  output int          mismatch_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_BYTES = 4;

  typedef enum logic [2:0] {
    AWAIT_VERSION, AWAIT_CRC, AWAIT_COUNT, IN_DESTS, IN_LENGTH, IN_PAYLOAD, IN_TRAILER
  } parse_stage_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] index;
    logic [7:0]  value;
    logic        last;
    logic        crc_ok;
    logic [7:0]  version;
  } deframe_result_t;

  parse_stage_t    stage;
  logic [31:0]     field_pos;
  logic [7:0]      ver_byte;
  logic [31:0]     crc_field;
  logic [7:0]      dest_total;
  logic [31:0]     length_field;
  logic [31:0]     crc_acc;
  deframe_result_t expected_results[$];
  int              results_seen;

  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_parser();
    stage        = AWAIT_VERSION;
    field_pos    = '0;
    ver_byte     = '0;
    crc_field    = '0;
    dest_total   = '0;
    length_field = '0;
    crc_acc      = CRC_INIT;
  endtask

  // advance the parse by one byte and queue the result it causes, if any
  task automatic parse_byte(input logic restart, input logic [7:0] b);
    deframe_result_t r;
    bit produces;
    r = '0;
    produces = 1'b0;
    if (restart) begin
      clear_parser();
      return;
    end
    unique case (stage)
      AWAIT_VERSION: begin
        ver_byte  = b;
        stage     = AWAIT_CRC;
        field_pos = '0;
      end
      AWAIT_CRC: begin
        crc_field = {crc_field[23:0], b};
        field_pos++;
        if (field_pos >= FIELD_BYTES) begin
          stage     = AWAIT_COUNT;
          field_pos = '0;
        end
      end
      AWAIT_COUNT: begin
        if (b == 8'h00) begin
          // rejected count, kept out of the crc
          r.kind   = KIND_ZERO;
          r.value  = b;
          produces = 1'b1;
        end else begin
          dest_total = b;
          crc_acc    = crc32_next(crc_acc, b);
          stage      = IN_DESTS;
          field_pos  = '0;
        end
      end
      IN_DESTS: begin
        r.kind  = KIND_DEST;
        r.index = field_pos;
        r.value = b;
        produces = 1'b1;
        crc_acc = crc32_next(crc_acc, b);
        field_pos++;
        if (field_pos >= dest_total) begin
          stage     = IN_LENGTH;
          field_pos = '0;
        end
      end
      IN_LENGTH: begin
        length_field = {length_field[23:0], b};
        crc_acc      = crc32_next(crc_acc, b);
        field_pos++;
        if (field_pos >= FIELD_BYTES) begin
          field_pos = '0;
          if (length_field == '0) begin
            stage    = IN_TRAILER;
            r.kind   = KIND_EMPTY;
            r.last   = 1'b1;
            produces = 1'b1;
          end else begin
            stage = IN_PAYLOAD;
          end
        end
      end
      IN_PAYLOAD: begin
        r.kind   = KIND_DATA;
        r.index  = field_pos;
        r.value  = b;
        produces = 1'b1;
        crc_acc  = crc32_next(crc_acc, b);
        if (field_pos >= length_field - 1) begin
          stage     = IN_TRAILER;
          field_pos = '0;
          r.last    = 1'b1;
        end else begin
          field_pos++;
        end
      end
      default: begin
        // trailing byte, index saturates
        stage    = IN_TRAILER;
        r.kind   = KIND_TRAIL;
        r.index  = field_pos;
        r.value  = b;
        produces = 1'b1;
        if (field_pos != 32'hFFFF_FFFF) field_pos++;
      end
    endcase
    if (produces) begin
      r.version = ver_byte;
      r.crc_ok  = r.last && ((crc_acc ^ 32'hFFFF_FFFF) == crc_field);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst) begin
      clear_parser();
      expected_results.delete();
      pending_results <= 0;
    end else begin
      // queue first so a same-edge result still lines up in order
      if (in_valid && in_ready) parse_byte(cmd, byte_in);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0h value %0h", kind, value));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(kind), 32'(want.kind));
          check_field("index", index, want.index);
          check_field("value", 32'(value), 32'(want.value));
          check_field("last", 32'(last), 32'(want.last));
          check_field("crc_ok", 32'(crc_ok), 32'(want.crc_ok));
          check_field("version", 32'(version), 32'(want.version));
        end
        results_seen++;
      end
      pending_results <= expected_results.size();
    end
  end

endmodule

/* bench/datagram_deframer_crc32_tb.sv */
// testbench top for datagram_deframer_crc32: builds datagram byte streams,
// drives both channels with random idling and gives the verdict
// depends on dgdf_pkg, datagram_deframer_crc32 and dgdf_result_checker
module datagram_deframer_crc32_tb
  import dgdf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [31:0] index;
  logic [7:0]  value;
  logic        last;
  logic        crc_ok;
  logic [7:0]  version;

  int          mismatches;
  int          pending_results;
  int          results_taken;
  int          items_sent;
  int          idle_count;
  bit          sender_burst;
  logic [7:0]  frame_bytes[$];

  datagram_deframer_crc32 dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .byte_in  (byte_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .index    (index),
    .value    (value),
    .last     (last),
    .crc_ok   (crc_ok),
    .version  (version)
  );

  dgdf_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .index          (index),
    .value          (value),
    .last           (last),
    .crc_ok         (crc_ok),
    .version        (version),
    .mismatch_count (mismatches),
    .pending_results(pending_results)
  );

  always #6 clk = ~clk;

  // zlib crc step, used to seal generated datagrams
  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic int pick_dest_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(200, 255);
  endfunction

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 75) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(100, 200);
  endfunction

  // lay out one datagram in frame_bytes; fill < 0 means random destination and payload bytes,
  // a bad crc has one bit flipped, zero count bytes go ahead of the real count
  task automatic build_datagram(input logic [7:0] ver, input int n_dest,
                                input logic [31:0] len_field, input int n_payload,
                                input int n_zero, input bit good_crc, input int fill);
    logic [7:0]  body[$];
    logic [31:0] c;
    body = {};
    body.push_back(8'(n_dest));
    for (int i = 0; i < n_dest; i++) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    for (int i = 3; i >= 0; i--) body.push_back(len_field[8*i +: 8]);
    for (int i = 0; i < n_payload; i++) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    c = CRC_INIT;
    foreach (body[i]) c = crc32_next(c, body[i]);
    c = ~c;
    if (!good_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
    frame_bytes = {};
    frame_bytes.push_back(ver);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(c[8*i +: 8]);
    repeat (n_zero) frame_bytes.push_back(8'h00);
    foreach (body[i]) frame_bytes.push_back(body[i]);
  endtask

  // one input transaction: optional gap, then hold until accepted
  task automatic send_item(input logic restart, input logic [7:0] b);
    int gap;
    gap = sender_burst ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= restart;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame(input int upto);
    for (int i = 0; i < upto; i++) send_item(1'b0, frame_bytes[i]);
  endtask

  // results taken, read by the receiver to time its long hold-offs
  always @(posedge clk) begin
    if (out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("datagram_deframer_crc32: mismatch");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // receiver: random stalls, ready bursts, and two long hold-offs that back
  // the block up into its input
  initial begin
    int holds;
    int gap;
    holds = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds < 2 && results_taken >= (holds == 0 ? 250 : 900)) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds++;
      end else begin
        gap = idle_cycles();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 19) == 0 ? $urandom_range(60, 150) : $urandom_range(1, 8))
          @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int         pick;
    int         nd;
    int         np;
    logic [31:0] huge_len;
    bit         pause_done;
    pause_done   = 1'b0;
    sender_burst = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme bytes, a rejected zero count, empty payload with a good
    // crc, a trailing byte, restart, then a one-byte payload with a bad crc
    build_datagram(8'hFF, 1, 32'h0, 0, 1, 1'b1, 8'hFF);
    send_frame(frame_bytes.size());
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'hFF);
    build_datagram(8'h00, 1, 32'h1, 1, 0, 1'b0, 8'h00);
    send_frame(frame_bytes.size());

    // random datagrams: mostly well formed, some cut short, some noise
    while (items_sent < ITEM_TARGET) begin
      if (!pause_done && items_sent >= ITEM_TARGET / 2) begin
        // sender goes quiet until the block has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        pause_done = 1'b1;
      end
      sender_burst = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      nd   = pick_dest_count();
      np   = pick_payload_len();
      if (pick < 70) begin
        send_item(1'b1, 8'($urandom));
        build_datagram(8'($urandom), nd, 32'(np), np,
                       $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0,
                       $urandom_range(0, 3) != 0, -1);
        send_frame(frame_bytes.size());
        repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom));
      end else if (pick < 85) begin
        // truncated datagram, the next restart discards it
        send_item(1'b1, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
          huge_len = $urandom | 32'h0100_0000;
          build_datagram(8'($urandom), nd, huge_len, $urandom_range(1, 10), 0, 1'b1, -1);
          send_frame(frame_bytes.size());
        end else begin
          build_datagram(8'($urandom), nd, 32'(np), np, 0, 1'b1, -1);
          send_frame($urandom_range(1, frame_bytes.size() - 1));
        end
      end else if (pick < 90) begin
        // datagram without a restart: lands on whatever state is left
        build_datagram(8'($urandom), nd, 32'(np), np, 0, 1'b1, -1);
        send_frame(frame_bytes.size());
      end else begin
        repeat ($urandom_range(1, 6)) send_item($urandom_range(0, 3) == 0, 8'($urandom));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("datagram_deframer_crc32: match");
    end else begin
      $display("datagram_deframer_crc32: mismatch");
    end
    $finish;
  end

endmodule
